// ----- hw/rtl/lgs_pkg.sv -----
package lgs_pkg;

	// field widths of the result transaction
	localparam int ROW_FIELD_W = 10;
	localparam int COL_FIELD_W = 7;

	// configuration port
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;
	localparam int ROW_COUNT_W = 11;
	localparam int COL_COUNT_W = 8;
	localparam int COUNT_RST   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

	// 3x3 window held as three column cells
	localparam int WIN_COLS = 3;

	// result queue
	localparam int OUT_DEPTH  = 8;
	localparam int PTR_W      = 3;
	localparam int LVL_W      = 4;
	localparam int PUSH_MAX   = 4;
	localparam int PUSH_CNT_W = 3;

	typedef struct packed {
		logic bot;
		logic mid;
		logic top;
	} column_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic                   next_alive;
		logic [ROW_FIELD_W-1:0] out_row;
		logic [COL_FIELD_W-1:0] out_col;
		logic                   gen_last;
	} result_t;

	typedef struct packed {
		logic [PUSH_CNT_W-1:0]      count;
		result_t [PUSH_MAX-1:0]     items;
	} push_t;

	// rule B3/S23 on the eight neighbors of a cell
	function automatic logic life_rule(input logic center, input logic [7:0] nb);
		logic [3:0] cnt;
		cnt = '0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + 4'(nb[i]);
		end
		return (cnt == 4'd3) || ((cnt == 4'd2) && center);
	endfunction

endpackage

// ----- hw/rtl/lgs_cell_if.sv -----
interface lgs_cell_if;
	logic valid;
	logic ready;
	logic cell_alive;

	modport source(output valid, output cell_alive, input ready);
	modport sink(input valid, input cell_alive, output ready);
endinterface

// ----- hw/rtl/lgs_result_if.sv -----
interface lgs_result_if;
	logic                           valid;
	logic                           ready;
	logic                           next_alive;
	logic [lgs_pkg::ROW_FIELD_W-1:0] out_row;
	logic [lgs_pkg::COL_FIELD_W-1:0] out_col;
	logic                           gen_last;

	modport source(output valid, output next_alive, output out_row, output out_col,
		output gen_last, input ready);
	modport sink(input valid, input next_alive, input out_row, input out_col,
		input gen_last, output ready);
endinterface

// ----- hw/rtl/life_generation_stencil_core.sv -----
// Next-generation engine for the Game of Life, rule B3/S23, on a streamed grid.
// cell_ch takes one current-generation cell per transaction, in raster order over
// a row_count by col_count grid; result_ch gives next-generation cells tagged with
// row and column, gen_last set on the final cell of the generation. Cells outside
// the grid are dead. row_count and col_count are written through the cfg port
// (index 0 and 1); the user writes them only while the block is idle, which the
// block itself does not enforce. 0 acts as 1, values above the maximum act as
// the maximum. Cell (r,c) is produced once cell (r+1,c+1) is taken; column ends
// and the last row come out in bursts of up to four results. An accepted cell
// is registered into the window cells and stage 1; its results are then written
// into an 8-entry result queue, whose head can be taken. Throughput is one cell
// per cycle inside the grid; the last row yields two results per cell, and
// cell_ch.ready drops whenever the queue could not hold four more results, so a
// stalled receiver backs the stream up without loss. The two preceding rows sit
// in one line RAM of MAX_COLS entries, read ahead of the cell that needs them.
// Reset clears the position, the window and the queue; both counts go to 32.
module life_generation_stencil_core #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	lgs_cell_if.sink                         cell_ch,
	lgs_result_if.source                     result_ch
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROWS_LAST_RST =
		((lgs_pkg::COUNT_RST > MAX_ROWS) ? MAX_ROWS : lgs_pkg::COUNT_RST) - 1;
	localparam int COLS_LAST_RST =
		((lgs_pkg::COUNT_RST > MAX_COLS) ? MAX_COLS : lgs_pkg::COUNT_RST) - 1;

	// configuration, held as the index of the last row and column
	logic [RW-1:0] rows_last_q;
	logic [CW-1:0] cols_last_q;
	logic [RW-1:0] rows_last_d;
	logic [CW-1:0] cols_last_d;
	logic [31:0]   row_cnt_w;
	logic [31:0]   col_cnt_w;

	assign row_cnt_w = 32'(cfg_wdata[lgs_pkg::ROW_COUNT_W-1:0]);
	assign col_cnt_w = 32'(cfg_wdata[lgs_pkg::COL_COUNT_W-1:0]);

	always_comb begin
		if (row_cnt_w == 32'd0) begin
			rows_last_d = '0;
		end else if (row_cnt_w > 32'(MAX_ROWS)) begin
			rows_last_d = RW'(MAX_ROWS - 1);
		end else begin
			rows_last_d = RW'(row_cnt_w - 32'd1);
		end
		if (col_cnt_w == 32'd0) begin
			cols_last_d = '0;
		end else if (col_cnt_w > 32'(MAX_COLS)) begin
			cols_last_d = CW'(MAX_COLS - 1);
		end else begin
			cols_last_d = CW'(col_cnt_w - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= RW'(ROWS_LAST_RST);
			cols_last_q <= CW'(COLS_LAST_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				lgs_pkg::REG_ROW_COUNT: rows_last_q <= rows_last_d;
				lgs_pkg::REG_COL_COUNT: cols_last_q <= cols_last_d;
				default: ;
			endcase
		end
	end

	// raster position of the next cell
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_next;
	logic [CW-1:0] col_next;
	logic          accept;
	logic          end_col;
	logic          end_row;

	assign accept   = cell_ch.valid & cell_ch.ready;
	assign end_col  = (col_q >= cols_last_q);
	assign end_row  = (row_q >= rows_last_q);
	assign col_next = end_col ? '0 : col_q + CW'(1);
	assign row_next = end_col ? (end_row ? '0 : row_q + RW'(1)) : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_next;
			col_q <= col_next;
		end
	end

	// line RAM: bit 1 the row two above, bit 0 the row just above
	logic [CW-1:0] rd_addr;
	logic [1:0]    ram_rdata;
	logic [1:0]    line_wdata;
	logic [1:0]    line_rd;
	logic          byp_q;
	logic [1:0]    byp_data_q;
	logic          up_bit;
	logic          mid_bit;

	assign rd_addr    = accept ? col_next : col_q;
	assign line_rd    = byp_q ? byp_data_q : ram_rdata;
	assign up_bit     = (32'(row_q) >= 32'd2) & line_rd[1];
	assign mid_bit    = (row_q != '0) & line_rd[0];
	assign line_wdata = {mid_bit, cell_ch.cell_alive};

	lgs_ram #(
		.WIDTH(2),
		.DEPTH(MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (line_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// single-column grid reads the entry written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= accept && (col_next == col_q);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= line_wdata;
	end

	// window: cell 0 holds column c, cell 1 column c-1, cell 2 column c-2
	lgs_pkg::column_t    new_col;
	lgs_pkg::column_t    win [lgs_pkg::WIN_COLS];
	lgs_pkg::column_t    win_in [lgs_pkg::WIN_COLS];
	lgs_pkg::cell_ctrl_t win_ctrl [lgs_pkg::WIN_COLS];

	assign new_col.top = up_bit;
	assign new_col.mid = mid_bit;
	assign new_col.bot = cell_ch.cell_alive;

	for (genvar k = 0; k < lgs_pkg::WIN_COLS; k++) begin : g_win
		if (k == 0) begin : g_first
			assign win_in[k]         = new_col;
			assign win_ctrl[k].shift = accept;
			assign win_ctrl[k].clear = 1'b0;
		end else begin : g_rest
			assign win_in[k]         = win[k-1];
			assign win_ctrl[k].shift = accept;
			assign win_ctrl[k].clear = (col_q == '0);
		end
		lgs_col_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (win_ctrl[k]),
			.prev_col (win_in[k]),
			.col      (win[k])
		);
	end

	// stage 1: position of the cell just shifted into the window
	logic          valid_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          end_col_s1;
	logic          end_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1     <= row_q;
			col_s1     <= col_q;
			end_col_s1 <= end_col;
			end_row_s1 <= end_row;
		end
	end

	// four candidates: row above at c-1 and c, current (last) row at c-1 and c
	lgs_pkg::column_t  c0;
	lgs_pkg::column_t  c1;
	lgs_pkg::column_t  c2;
	lgs_pkg::result_t  cand [lgs_pkg::PUSH_MAX];
	logic [lgs_pkg::PUSH_MAX-1:0] cand_ok;
	logic [lgs_pkg::ROW_FIELD_W-1:0] row_up_f;
	logic [lgs_pkg::ROW_FIELD_W-1:0] row_f;
	logic [lgs_pkg::COL_FIELD_W-1:0] col_left_f;
	logic [lgs_pkg::COL_FIELD_W-1:0] col_f;
	lgs_pkg::push_t    push;
	logic [lgs_pkg::PUSH_CNT_W-1:0] n_s1;
	logic [lgs_pkg::LVL_W-1:0]      fifo_level;

	assign c0 = win[0];
	assign c1 = win[1];
	assign c2 = win[2];

	assign row_up_f   = lgs_pkg::ROW_FIELD_W'(row_s1 - RW'(1));
	assign row_f      = lgs_pkg::ROW_FIELD_W'(row_s1);
	assign col_left_f = lgs_pkg::COL_FIELD_W'(col_s1 - CW'(1));
	assign col_f      = lgs_pkg::COL_FIELD_W'(col_s1);

	assign cand_ok[0] = valid_s1 && (row_s1 != '0) && (col_s1 != '0);
	assign cand_ok[1] = valid_s1 && (row_s1 != '0) && end_col_s1;
	assign cand_ok[2] = valid_s1 && end_row_s1 && (col_s1 != '0);
	assign cand_ok[3] = valid_s1 && end_row_s1 && end_col_s1;

	always_comb begin
		cand[0].next_alive = lgs_pkg::life_rule(c1.mid,
			{c0.top, c0.mid, c0.bot, c1.top, c1.bot, c2.top, c2.mid, c2.bot});
		cand[0].out_row    = row_up_f;
		cand[0].out_col    = col_left_f;
		cand[0].gen_last   = 1'b0;
		// right of column c is outside the grid
		cand[1].next_alive = lgs_pkg::life_rule(c0.mid,
			{c0.top, c0.bot, c1.top, c1.mid, c1.bot, 3'b000});
		cand[1].out_row    = row_up_f;
		cand[1].out_col    = col_f;
		cand[1].gen_last   = 1'b0;
		// below the last row is outside the grid
		cand[2].next_alive = lgs_pkg::life_rule(c1.bot,
			{c0.mid, c0.bot, c1.mid, c2.mid, c2.bot, 3'b000});
		cand[2].out_row    = row_f;
		cand[2].out_col    = col_left_f;
		cand[2].gen_last   = 1'b0;
		cand[3].next_alive = lgs_pkg::life_rule(c0.bot,
			{c0.mid, c1.mid, c1.bot, 5'b00000});
		cand[3].out_row    = row_f;
		cand[3].out_col    = col_f;
		cand[3].gen_last   = 1'b1;
	end

	// pack the valid candidates in order
	always_comb begin
		logic [lgs_pkg::PUSH_CNT_W-1:0] k;
		k = '0;
		for (int j = 0; j < lgs_pkg::PUSH_MAX; j++) begin
			push.items[j] = cand[j];
		end
		for (int j = 0; j < lgs_pkg::PUSH_MAX; j++) begin
			if (cand_ok[j]) begin
				push.items[k[1:0]] = cand[j];
				k = k + lgs_pkg::PUSH_CNT_W'(1);
			end
		end
		push.count = k;
	end

	assign n_s1 = push.count;

	lgs_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (fifo_level),
		.out_ch (result_ch)
	);

	// room for the transaction still in stage 1 and a full burst behind it
	assign cell_ch.ready = ((5'(fifo_level) + 5'(n_s1)) <=
		5'(lgs_pkg::OUT_DEPTH - lgs_pkg::PUSH_MAX));

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((5'(fifo_level) + 5'(n_s1)) <= 5'(lgs_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_col && end_row) |=> ((row_q == '0) && (col_q == '0)))
		else $error("position did not wrap at end of generation");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_COLS))
		else $error("column position beyond line ram");

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cand_ok[3] |-> (valid_s1 && end_row_s1 && end_col_s1))
		else $error("end of generation flagged off the last cell");

endmodule

// ----- hw/rtl/lgs_ram.sv -----
module lgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/lgs_col_cell.sv -----
module lgs_col_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgs_pkg::cell_ctrl_t  ctrl,
	input  lgs_pkg::column_t     prev_col,
	output lgs_pkg::column_t     col
);

	lgs_pkg::column_t col_q;

	// a cleared cell takes a dead column (left of the grid edge)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= ctrl.clear ? '0 : prev_col;
		end
	end

	assign col = col_q;

endmodule

// ----- hw/rtl/lgs_out_fifo.sv -----
module lgs_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lgs_pkg::push_t                    push,
	output logic [lgs_pkg::LVL_W-1:0]         level,
	lgs_result_if.source                      out_ch
);

	lgs_pkg::result_t                 mem_q [lgs_pkg::OUT_DEPTH];
	logic [lgs_pkg::PTR_W-1:0]        wr_ptr_q;
	logic [lgs_pkg::PTR_W-1:0]        rd_ptr_q;
	logic [lgs_pkg::LVL_W-1:0]        level_q;
	lgs_pkg::result_t                 head;
	logic                             pop;

	assign head              = mem_q[rd_ptr_q];
	assign out_ch.valid      = (level_q != '0);
	assign out_ch.next_alive = head.next_alive;
	assign out_ch.out_row    = head.out_row;
	assign out_ch.out_col    = head.out_col;
	assign out_ch.gen_last   = head.gen_last;
	assign pop               = out_ch.valid & out_ch.ready;
	assign level             = level_q;

	// up to four results land in consecutive slots in a single write
	always_ff @(posedge clk) begin
		for (int k = 0; k < lgs_pkg::PUSH_MAX; k++) begin
			if (lgs_pkg::PUSH_CNT_W'(k) < push.count) begin
				mem_q[wr_ptr_q + lgs_pkg::PTR_W'(k)] <= push.items[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lgs_pkg::PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + lgs_pkg::PTR_W'(pop);
			level_q  <= level_q + lgs_pkg::LVL_W'(push.count) - lgs_pkg::LVL_W'(pop);
		end
	end

endmodule

// ----- test/tb_life_generation_stencil_core.sv -----
`timescale 1ns / 1ps

module tb_life_generation_stencil_core;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 1024;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata;

	lgs_cell_if   cell_ch();
	lgs_result_if result_ch();

	life_generation_stencil_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cell_ch(cell_ch),
		.result_ch(result_ch)
	);

	// predictor copy of the grid engine
	logic                            row_above_two [MAX_COLS];
	logic                            row_above_one [MAX_COLS];
	logic [8:0]                      window;
	logic [lgs_pkg::ROW_FIELD_W-1:0] cur_row;
	logic [lgs_pkg::COL_FIELD_W-1:0] cur_col;
	logic [lgs_pkg::ROW_COUNT_W-1:0] rows_reg;
	logic [lgs_pkg::COL_COUNT_W-1:0] cols_reg;

	lgs_pkg::result_t next_gen_q[$];
	int      mismatch_count = 0;
	int      cells_sent = 0;
	int      src_idle_pct = 0;
	int      sink_stall_pct = 0;

	always #1 clk = ~clk;

	function automatic int clamp_count(input int v, input int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// centre is bit 4, the other eight bits are the neighbors
	function automatic logic b3s23(input logic [8:0] nb);
		int n;
		n = $countones(nb & 9'h1EF);
		return (n == 3) || (n == 2 && nb[4]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic push_next_cell(input logic alive, input int r, input int c, input logic last);
		lgs_pkg::result_t e;
		e.next_alive = alive;
		e.out_row    = lgs_pkg::ROW_FIELD_W'(r);
		e.out_col    = lgs_pkg::COL_FIELD_W'(c);
		e.gen_last   = last;
		next_gen_q   = {next_gen_q, e};
	endtask

	task automatic reset_stencil();
		for (int i = 0; i < MAX_COLS; i++) begin
			row_above_two[i] = 1'b0;
			row_above_one[i] = 1'b0;
		end
		window   = '0;
		cur_row  = '0;
		cur_col  = '0;
		rows_reg = lgs_pkg::ROW_COUNT_W'(lgs_pkg::COUNT_RST);
		cols_reg = lgs_pkg::COL_COUNT_W'(lgs_pkg::COUNT_RST);
	endtask

	task automatic advance_stencil(input logic cell_bit);
		int         rows, cols, r, c;
		logic       u, m, end_col, end_row;
		logic [8:0] w, wend;
		rows    = clamp_count(int'(rows_reg), MAX_ROWS);
		cols    = clamp_count(int'(cols_reg), MAX_COLS);
		r       = int'(cur_row);
		c       = int'(cur_col);
		end_col = (c >= cols - 1);
		end_row = (r >= rows - 1);
		u       = (r >= 2) ? row_above_two[c] : 1'b0;
		m       = (r >= 1) ? row_above_one[c] : 1'b0;
		row_above_two[c] = m;
		row_above_one[c] = cell_bit;
		w      = (c == 0) ? 9'h000 : window;
		w      = ((w << 1) & 9'h1B6) | {2'b00, cell_bit, 2'b00, m, 2'b00, u};
		window = w;
		// one more shift with dead cells on the right for the column end
		wend   = (w << 1) & 9'h1B6;
		if (r >= 1) begin
			if (c >= 1)
				push_next_cell(b3s23(w), r - 1, c - 1, 1'b0);
			if (end_col)
				push_next_cell(b3s23(wend), r - 1, c, 1'b0);
		end
		if (end_row) begin
			if (c >= 1)
				push_next_cell(b3s23(w >> 3), r, c - 1, 1'b0);
			if (end_col)
				push_next_cell(b3s23(wend >> 3), r, c, 1'b1);
		end
		if (end_col) begin
			cur_col = '0;
			cur_row = end_row ? '0 : lgs_pkg::ROW_FIELD_W'(r + 1);
		end else begin
			cur_col = lgs_pkg::COL_FIELD_W'(c + 1);
		end
	endtask

	task automatic send_cell(input logic alive);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			cell_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_ch.valid      <= 1'b1;
		cell_ch.cell_alive <= alive;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
		advance_stencil(alive);
		cells_sent++;
	endtask

	task automatic wait_results_drained();
		cell_ch.valid <= 1'b0;
		@(posedge clk);
		while (next_gen_q.size() != 0)
			@(posedge clk);
		// row 0 cells give no result and may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [lgs_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= lgs_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lgs_pkg::REG_ROW_COUNT)
			rows_reg = lgs_pkg::ROW_COUNT_W'(value);
		else
			cols_reg = lgs_pkg::COL_COUNT_W'(value);
		@(posedge clk);
	endtask

	task automatic finish_generation(input int pct);
		while (cur_row != 0 || cur_col != 0)
			send_cell($urandom_range(99) < pct);
	endtask

	task automatic run_generation(input int rows, input int cols, input int pct);
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, rows);
		write_count(lgs_pkg::REG_COL_COUNT, cols);
		send_cell($urandom_range(99) < pct);
		finish_generation(pct);
	endtask

	task automatic run_pattern(input int rows, input int cols, input logic [15:0] cells);
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, rows);
		write_count(lgs_pkg::REG_COL_COUNT, cols);
		for (int i = 0; i < clamp_count(rows, MAX_ROWS) * clamp_count(cols, MAX_COLS); i++)
			send_cell(cells[i]);
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// reset counts 32x32, then the row count drops to zero mid-generation
	task automatic test_default_counts();
		repeat (32) send_cell($urandom_range(99) < 40);
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, 0);
		finish_generation(40);
	endtask

	task automatic test_directed_patterns();
		run_pattern(0, 0, 16'h0001);
		run_pattern(1, 1, 16'h0000);
		// vertical blinker turns horizontal
		run_pattern(3, 3, 16'h0092);
		// all alive: only the corners survive
		run_pattern(3, 3, 16'h01FF);
		// three alive in a 2x2 gives a birth
		run_pattern(2, 2, 16'h0007);
	endtask

	// column count lowered below the current column in the middle of a row
	task automatic test_col_shrink_midrow();
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, 4);
		write_count(lgs_pkg::REG_COL_COUNT, 8);
		repeat (11) send_cell($urandom_range(99) < 50);
		wait_results_drained();
		write_count(lgs_pkg::REG_COL_COUNT, 2);
		finish_generation(50);
	endtask

	task automatic test_extreme_counts();
		run_generation(1, 'h7FF, 50);
		// row count above the maximum on a single column, cut short later
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, 'h7FF);
		write_count(lgs_pkg::REG_COL_COUNT, 1);
		repeat (3) send_cell($urandom_range(99) < 50);
		wait_results_drained();
		write_count(lgs_pkg::REG_ROW_COUNT, 0);
		finish_generation(50);
	endtask

	task automatic test_random_generations(input int target);
		int  start, rows, cols, pct;
		bit  paused;
		start  = cells_sent;
		paused = 1'b0;
		while (cells_sent - start < target) begin
			if ($urandom_range(7) == 0) begin
				rows = $urandom_range(0, 1);
				cols = $urandom_range(20, 255);
			end else begin
				rows = $urandom_range(0, 7);
				cols = $urandom_range(0, 9);
			end
			pct = $urandom_range(15, 60);
			wait_results_drained();
			write_count(lgs_pkg::REG_COL_COUNT, cols);
			write_count(lgs_pkg::REG_ROW_COUNT, rows);
			do begin
				send_cell($urandom_range(99) < pct);
				if (!paused && cur_row >= 2 && $urandom_range(3) == 0) begin
					wait_results_drained();
					paused = 1'b1;
				end
			end while (cur_row != 0 || cur_col != 0);
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin : result_check
		lgs_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (next_gen_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction row %0d col %0d",
					result_ch.out_row, result_ch.out_col));
			end else begin
				want = next_gen_q.pop_front();
				if (result_ch.next_alive !== want.next_alive)
					report_mismatch($sformatf("next_alive %0b, want %0b at row %0d col %0d",
						result_ch.next_alive, want.next_alive, want.out_row, want.out_col));
				if (result_ch.out_row !== want.out_row)
					report_mismatch($sformatf("out_row %0d, want %0d",
						result_ch.out_row, want.out_row));
				if (result_ch.out_col !== want.out_col)
					report_mismatch($sformatf("out_col %0d, want %0d",
						result_ch.out_col, want.out_col));
				if (result_ch.gen_last !== want.gen_last)
					report_mismatch($sformatf("gen_last %0b, want %0b at row %0d col %0d",
						result_ch.gen_last, want.gen_last, want.out_row, want.out_col));
			end
		end
		result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		cell_ch.valid      = 1'b0;
		cell_ch.cell_alive = 1'b0;
		reset_stencil();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_counts();
		test_directed_patterns();
		test_col_shrink_midrow();
		test_extreme_counts();

		set_idling(0, 0);
		test_random_generations(12);
		set_idling(74, 0);
		test_random_generations(12);
		set_idling(0, 74);
		test_random_generations(12);
		set_idling(23, 23);
		test_random_generations(12);

		wait_results_drained();
		if (mismatch_count == 0)
			$display("PASS life_generation_stencil_core");
		else
			$display("FAIL life_generation_stencil_core");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL life_generation_stencil_core");
		$finish;
	end

endmodule
